@@ rtl/core/ahx_pkg.sv @@
// ----------------------------------------------------------------------------
// ahx_pkg
// Shared types, constants and helper functions of the ascii hex register slave
// ----------------------------------------------------------------------------
package ahx_pkg;

  // sizes
  localparam int RegCount      = 64;
  localparam int RegAw         = 6;
  localparam int MaxFrameBytes = 64;
  localparam int FrameAw       = 6;
  localparam int MaxReadRegs   = 8;
  localparam int MinFrame      = 9;

  // crc
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // framing characters
  localparam logic [7:0] ChStart = 8'h24;
  localparam logic [7:0] ChEnd   = 8'h21;

  // frame types
  localparam logic [7:0] FrameRequest  = 8'd1;
  localparam logic [7:0] FrameResponse = 8'd2;

  // function codes
  localparam logic [7:0] FnRead       = 8'd1;
  localparam logic [7:0] FnWrite      = 8'd2;
  localparam logic [7:0] FnReadMulti  = 8'd3;
  localparam logic [7:0] FnWriteMulti = 8'd4;

  // input operations
  localparam logic [1:0] OpChar    = 2'd0;
  localparam logic [1:0] OpHostWr  = 2'd1;
  localparam logic [1:0] OpHostRd  = 2'd2;

  // result kinds
  localparam logic KindChar = 1'b0;
  localparam logic KindRead = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_H_WT,
    ST_H_OUT,
    ST_C_CHK,
    ST_C_WT,
    ST_C_USE,
    ST_C_CRCW,
    ST_C_EVAL,
    ST_W_ONE,
    ST_WM_H,
    ST_WM_HW,
    ST_WM_HU,
    ST_WM_LW,
    ST_WM_LU,
    ST_T_DOL,
    ST_T_FETCH,
    ST_T_FWT,
    ST_T_BYTE,
    ST_T_HI,
    ST_T_LO,
    ST_T_NX,
    ST_T_END
  } seq_state_t;

  // control towards the crc unit
  typedef struct packed {
    logic       clr;
    logic       load;
    logic [7:0] data;
  } crc_ctl_t;

  // one result towards the output register
  typedef struct packed {
    logic        valid;
    logic        kind;
    logic [7:0]  ch;
    logic        last;
    logic [15:0] word;
  } emit_t;

  // ascii character to nibble value, other characters keep their raw value
  function automatic logic [7:0] nib_val(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h30 && c <= 8'h39) r = c - 8'h30;
    else if (c >= 8'h41 && c <= 8'h46) r = c - 8'h37;
    return r;
  endfunction

  // nibble to uppercase hex character
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] r;
    r = (v <= 4'd9) ? ({4'd0, v} + 8'h30) : ({4'd0, v} + 8'h37);
    return r;
  endfunction

endpackage

@@ rtl/core/ahx_crc.sv @@
// ----------------------------------------------------------------------------
// ahx_crc
// Bit-serial crc16 unit, reflected poly, one shift per cycle, eight per byte
// ----------------------------------------------------------------------------
module ahx_crc (
  input  logic              clk,
  input  logic              rst,
  input  ahx_pkg::crc_ctl_t ctl,
  output logic              busy,
  output logic [15:0]       crc
);

  logic [3:0] cnt;

  assign busy = (cnt != 4'd0);

  // shift register and bit counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 4'd0;
      crc <= ahx_pkg::CrcInit;
    end else if (ctl.clr) begin
      cnt <= 4'd0;
      crc <= ahx_pkg::CrcInit;
    end else if (ctl.load) begin
      cnt <= 4'd8;
      crc <= crc ^ {8'd0, ctl.data};
    end else if (busy) begin
      cnt <= cnt - 4'd1;
      crc <= crc[0] ? ((crc >> 1) ^ ahx_pkg::CrcPoly) : (crc >> 1);
    end
  end

endmodule

@@ rtl/core/ahx_seq.sv @@
// ----------------------------------------------------------------------------
// ahx_seq
// Frame decoder, request handler, host access handler and response sequencer around the crc unit
// ----------------------------------------------------------------------------
module ahx_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic [7:0]         in_char,
  input  logic [5:0]         in_idx,
  input  logic [15:0]        in_data,
  input  logic               slot_free,
  output ahx_pkg::emit_t     emit
);

  ahx_pkg::seq_state_t state, state_next;

  logic        in_frame, in_frame_next;
  logic        nib_pend, nib_pend_next;
  logic [7:0]  high_nib, high_nib_next;
  logic [6:0]  bc, bc_next;
  logic        ovf, ovf_next;
  logic [15:0] la;
  logic [9:0]  fidx, fidx_next;
  logic [7:0]  fdata;
  logic        fvld;
  logic [5:0]  raddr, raddr_next;
  logic        rin, rin_next;
  logic [15:0] rdata;
  logic        rvld;
  logic [7:0]  cap [12];
  logic [7:0]  cap_next [12];
  logic [7:0]  chk_hi, chk_hi_next, chk_lo, chk_lo_next;
  logic [7:0]  cnt, cnt_next;
  logic        status, status_next;
  logic [4:0]  j, j_next;
  logic [4:0]  rlen, rlen_next;
  logic [7:0]  cur, cur_next;
  logic [7:0]  tmp_hi, tmp_hi_next;

  // memories
  localparam int MemFrameDepth = ahx_pkg::MaxFrameBytes;
  logic [7:0]  frame_mem [MemFrameDepth];
  logic [15:0] reg_mem   [ahx_pkg::RegCount];
  logic [ahx_pkg::RegCount-1:0] reg_valid;

  logic                    fm_we;
  logic [ahx_pkg::FrameAw-1:0] fm_wa;
  logic [7:0]              fm_wd;
  logic                    rm_we;
  logic [ahx_pkg::RegAw-1:0] rm_wa;
  logic [15:0]             rm_wd;

  // crc unit
  ahx_pkg::crc_ctl_t crc_ctl;
  logic              crc_busy;
  logic [15:0]       crc;

  ahx_crc u_crc (
    .clk  (clk),
    .rst  (rst),
    .ctl  (crc_ctl),
    .busy (crc_busy),
    .crc  (crc)
  );

  // derived values
  logic [7:0]  fbyte;
  logic [15:0] req_addr;
  logic [7:0]  fn, num;
  logic [15:0] reg_word;
  logic [16:0] wsum;
  logic [3:0]  widx;
  logic [4:0]  jm;
  logic [7:0]  tx_byte;
  logic [16:0] wm_addr;

  assign fbyte    = fvld ? fdata : 8'd0;
  assign req_addr = {cap[8], cap[9]};
  assign fn       = cap[7];
  assign num      = cap[10];
  assign reg_word = rin ? (rvld ? rdata : 16'd0) : 16'hFFFF;
  assign jm       = j - 5'd11;
  assign widx     = (fn == ahx_pkg::FnReadMulti) ? jm[4:1] : 4'd0;
  assign wsum     = {1'b0, req_addr} + {13'd0, widx};
  assign wm_addr  = {1'b0, req_addr} + {9'd0, cnt};

  // response byte at position j
  always_comb begin
    tx_byte = 8'd0;
    if (j == rlen) begin
      tx_byte = crc[15:8];
    end else if (j == rlen + 5'd1) begin
      tx_byte = crc[7:0];
    end else begin
      case (j)
        5'd0: tx_byte = cap[0];
        5'd1: tx_byte = cap[1];
        5'd2: tx_byte = la[15:8];
        5'd3: tx_byte = la[7:0];
        5'd4: tx_byte = ahx_pkg::FrameResponse;
        5'd5: tx_byte = cap[5];
        5'd6: tx_byte = cap[6];
        5'd7: tx_byte = cap[7];
        5'd8: tx_byte = (fn == ahx_pkg::FnWrite || fn == ahx_pkg::FnWriteMulti) ?
                        {7'd0, status} : cap[8];
        5'd9: tx_byte = cap[9];
        5'd10: tx_byte = (fn == ahx_pkg::FnRead) ? reg_word[15:8] : cap[10];
        default: begin
          if (fn == ahx_pkg::FnRead) tx_byte = reg_word[7:0];
          else tx_byte = jm[0] ? reg_word[7:0] : reg_word[15:8];
        end
      endcase
    end
  end

  assign in_ready = (state == ahx_pkg::ST_IDLE);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) la <= 16'd0;
    else if (cfg_we) la <= cfg_wdata;
  end

  // frame byte store
  always_ff @(posedge clk) begin
    if (fm_we) frame_mem[fm_wa] <= fm_wd;
    fdata <= frame_mem[fidx[ahx_pkg::FrameAw-1:0]];
    fvld  <= (fidx < {3'd0, bc});
  end

  // register file, valid bits stand for the reset value
  always_ff @(posedge clk) begin
    if (rm_we) reg_mem[rm_wa] <= rm_wd;
    rdata <= reg_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_valid <= '0;
      rvld      <= 1'b0;
    end else begin
      if (rm_we) reg_valid[rm_wa] <= 1'b1;
      rvld <= reg_valid[raddr];
    end
  end

  // state and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ahx_pkg::ST_IDLE;
      in_frame <= 1'b0;
      nib_pend <= 1'b0;
      high_nib <= 8'd0;
      bc       <= 7'd0;
      ovf      <= 1'b0;
    end else begin
      state    <= state_next;
      in_frame <= in_frame_next;
      nib_pend <= nib_pend_next;
      high_nib <= high_nib_next;
      bc       <= bc_next;
      ovf      <= ovf_next;
    end
    fidx   <= fidx_next;
    raddr  <= raddr_next;
    rin    <= rin_next;
    cap    <= cap_next;
    chk_hi <= chk_hi_next;
    chk_lo <= chk_lo_next;
    cnt    <= cnt_next;
    status <= status_next;
    j      <= j_next;
    rlen   <= rlen_next;
    cur    <= cur_next;
    tmp_hi <= tmp_hi_next;
  end

  // sequencer
  always_comb begin
    state_next    = state;
    in_frame_next = in_frame;
    nib_pend_next = nib_pend;
    high_nib_next = high_nib;
    bc_next       = bc;
    ovf_next      = ovf;
    fidx_next     = fidx;
    raddr_next    = raddr;
    rin_next      = rin;
    cap_next      = cap;
    chk_hi_next   = chk_hi;
    chk_lo_next   = chk_lo;
    cnt_next      = cnt;
    status_next   = status;
    j_next        = j;
    rlen_next     = rlen;
    cur_next      = cur;
    tmp_hi_next   = tmp_hi;
    fm_we         = 1'b0;
    fm_wa         = bc[ahx_pkg::FrameAw-1:0];
    fm_wd         = {high_nib[3:0], 4'd0} + ahx_pkg::nib_val(in_char);
    rm_we         = 1'b0;
    rm_wa         = in_idx;
    rm_wd         = in_data;
    crc_ctl       = '0;
    emit          = '0;

    case (state)
      ahx_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_op)
            ahx_pkg::OpHostWr: begin
              rm_we = 1'b1;
            end
            ahx_pkg::OpHostRd: begin
              raddr_next = in_idx;
              rin_next   = 1'b1;
              state_next = ahx_pkg::ST_H_WT;
            end
            ahx_pkg::OpChar: begin
              if (in_char == ahx_pkg::ChStart) begin
                in_frame_next = 1'b1;
                nib_pend_next = 1'b0;
                high_nib_next = 8'd0;
                bc_next       = 7'd0;
                ovf_next      = 1'b0;
              end else if (in_frame) begin
                if (in_char == ahx_pkg::ChEnd) begin
                  in_frame_next = 1'b0;
                  nib_pend_next = 1'b0;
                  state_next    = ahx_pkg::ST_C_CHK;
                end else if (!nib_pend) begin
                  high_nib_next = ahx_pkg::nib_val(in_char);
                  nib_pend_next = 1'b1;
                end else begin
                  nib_pend_next = 1'b0;
                  if (bc < 7'(ahx_pkg::MaxFrameBytes)) begin
                    fm_we   = 1'b1;
                    bc_next = bc + 7'd1;
                  end else begin
                    ovf_next = 1'b1;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end

      // host read
      ahx_pkg::ST_H_WT: state_next = ahx_pkg::ST_H_OUT;
      ahx_pkg::ST_H_OUT: begin
        if (slot_free) begin
          emit.valid = 1'b1;
          emit.kind  = ahx_pkg::KindRead;
          emit.last  = 1'b1;
          emit.word  = reg_word;
          state_next = ahx_pkg::ST_IDLE;
        end
      end

      // frame check: crc pass over the stored bytes
      ahx_pkg::ST_C_CHK: begin
        if (ovf || bc < 7'(ahx_pkg::MinFrame)) begin
          state_next = ahx_pkg::ST_IDLE;
        end else begin
          for (int k = 0; k < 12; k++) cap_next[k] = 8'd0;
          crc_ctl.clr = 1'b1;
          fidx_next   = 10'd0;
          state_next  = ahx_pkg::ST_C_WT;
        end
      end
      ahx_pkg::ST_C_WT: state_next = ahx_pkg::ST_C_USE;
      ahx_pkg::ST_C_USE: begin
        if (fidx < 10'd12) cap_next[fidx[3:0]] = fbyte;
        if (fidx + 10'd2 < {3'd0, bc}) begin
          crc_ctl.load = 1'b1;
          crc_ctl.data = fbyte;
        end else if (fidx + 10'd2 == {3'd0, bc}) begin
          chk_hi_next = fbyte;
        end else begin
          chk_lo_next = fbyte;
        end
        state_next = ahx_pkg::ST_C_CRCW;
      end
      ahx_pkg::ST_C_CRCW: begin
        if (!crc_busy) begin
          if (fidx + 10'd1 == {3'd0, bc}) begin
            state_next = ahx_pkg::ST_C_EVAL;
          end else begin
            fidx_next  = fidx + 10'd1;
            state_next = ahx_pkg::ST_C_WT;
          end
        end
      end

      // accept or drop, then dispatch on function code
      ahx_pkg::ST_C_EVAL: begin
        state_next = ahx_pkg::ST_IDLE;
        if ({cap[5], cap[6]} == la && {chk_hi, chk_lo} == crc &&
            cap[4] == ahx_pkg::FrameRequest) begin
          case (fn)
            ahx_pkg::FnRead: begin
              rlen_next  = 5'd12;
              state_next = ahx_pkg::ST_T_DOL;
            end
            ahx_pkg::FnWrite: begin
              rlen_next  = 5'd9;
              state_next = ahx_pkg::ST_W_ONE;
            end
            ahx_pkg::FnReadMulti: begin
              rlen_next = 5'd11 + {num[3:0], 1'b0};
              if (num <= 8'(ahx_pkg::MaxReadRegs)) state_next = ahx_pkg::ST_T_DOL;
            end
            ahx_pkg::FnWriteMulti: begin
              rlen_next   = 5'd9;
              status_next = 1'b1;
              cnt_next    = 8'd0;
              state_next  = (num == 8'd0) ? ahx_pkg::ST_T_DOL : ahx_pkg::ST_WM_H;
            end
            default: ;
          endcase
        end
      end

      // single write
      ahx_pkg::ST_W_ONE: begin
        rm_wa = req_addr[ahx_pkg::RegAw-1:0];
        rm_wd = {cap[10], cap[11]};
        if (req_addr < 16'(ahx_pkg::RegCount)) begin
          rm_we       = 1'b1;
          status_next = 1'b1;
        end else begin
          status_next = 1'b0;
        end
        state_next = ahx_pkg::ST_T_DOL;
      end

      // write multiple, one word per pass
      ahx_pkg::ST_WM_H: begin
        fidx_next  = 10'd11 + {1'b0, cnt, 1'b0};
        state_next = ahx_pkg::ST_WM_HW;
      end
      ahx_pkg::ST_WM_HW: state_next = ahx_pkg::ST_WM_HU;
      ahx_pkg::ST_WM_HU: begin
        tmp_hi_next = fbyte;
        fidx_next   = fidx + 10'd1;
        state_next  = ahx_pkg::ST_WM_LW;
      end
      ahx_pkg::ST_WM_LW: state_next = ahx_pkg::ST_WM_LU;
      ahx_pkg::ST_WM_LU: begin
        rm_wa = wm_addr[ahx_pkg::RegAw-1:0];
        rm_wd = {tmp_hi, fbyte};
        if (wm_addr < 17'(ahx_pkg::RegCount)) begin
          rm_we       = 1'b1;
          status_next = 1'b1;
        end else begin
          status_next = 1'b0;
        end
        cnt_next = cnt + 8'd1;
        if ({1'b0, cnt} + 9'd1 == {1'b0, num}) state_next = ahx_pkg::ST_T_DOL;
        else state_next = ahx_pkg::ST_WM_H;
      end

      // response transmit
      ahx_pkg::ST_T_DOL: begin
        if (slot_free) begin
          emit.valid  = 1'b1;
          emit.kind   = ahx_pkg::KindChar;
          emit.ch     = ahx_pkg::ChStart;
          crc_ctl.clr = 1'b1;
          j_next      = 5'd0;
          state_next  = ahx_pkg::ST_T_FETCH;
        end
      end
      ahx_pkg::ST_T_FETCH: begin
        raddr_next = wsum[ahx_pkg::RegAw-1:0];
        rin_next   = (wsum < 17'(ahx_pkg::RegCount));
        state_next = ahx_pkg::ST_T_FWT;
      end
      ahx_pkg::ST_T_FWT: state_next = ahx_pkg::ST_T_BYTE;
      ahx_pkg::ST_T_BYTE: begin
        cur_next = tx_byte;
        if (j < rlen) begin
          crc_ctl.load = 1'b1;
          crc_ctl.data = tx_byte;
        end
        state_next = ahx_pkg::ST_T_HI;
      end
      ahx_pkg::ST_T_HI: begin
        if (slot_free) begin
          emit.valid = 1'b1;
          emit.ch    = ahx_pkg::hex_char(cur[7:4]);
          state_next = ahx_pkg::ST_T_LO;
        end
      end
      ahx_pkg::ST_T_LO: begin
        if (slot_free) begin
          emit.valid = 1'b1;
          emit.ch    = ahx_pkg::hex_char(cur[3:0]);
          state_next = ahx_pkg::ST_T_NX;
        end
      end
      ahx_pkg::ST_T_NX: begin
        if (!crc_busy) begin
          j_next     = j + 5'd1;
          state_next = (j == rlen + 5'd1) ? ahx_pkg::ST_T_END : ahx_pkg::ST_T_FETCH;
        end
      end
      ahx_pkg::ST_T_END: begin
        if (slot_free) begin
          emit.valid = 1'b1;
          emit.ch    = ahx_pkg::ChEnd;
          emit.last  = 1'b1;
          state_next = ahx_pkg::ST_IDLE;
        end
      end
      default: state_next = ahx_pkg::ST_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  // a result is only produced when the output register can take it
  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    emit.valid |-> slot_free) else $error("result produced into a full slot");

  // byte count never passes the frame store depth
  a_bc_range: assert property (@(posedge clk) disable iff (rst)
    bc <= 7'(ahx_pkg::MaxFrameBytes)) else $error("byte count out of range");

  // the crc unit is never loaded while still shifting
  a_crc_load: assert property (@(posedge clk) disable iff (rst)
    crc_ctl.load |-> !crc_busy) else $error("crc loaded while busy");

  // a host read answers in its own single result
  a_hread: assert property (@(posedge clk) disable iff (rst)
    (state == ahx_pkg::ST_H_OUT && emit.valid) |-> (emit.kind == ahx_pkg::KindRead && emit.last))
    else $error("host read result malformed");
`endif

endmodule

@@ rtl/core/ascii_hex_register_slave_top.sv @@
// ----------------------------------------------------------------------------
// ascii_hex_register_slave_top
// ASCII hex framed register slave with crc16 check and response generation
// ----------------------------------------------------------------------------
// Usage:
// s_axis carries one transaction per received character or host access;
// tuser selects the operation (character, host register write, host read).
// m_axis returns response characters ('$', uppercase hex, '!' with tlast)
// or a single host read word (tuser high, tlast high).
// cfg_we / cfg_wdata load the local bus address at any edge.
// Timing: a character or host write is taken in the idle state; a host read
// passes through the read wait and output states. A closing '!' walks the
// frame store once through the bit-serial crc unit, then sends each response
// byte as two hex characters, each byte paced by the crc step and the
// registered register read.
// s_axis_tready is low while a frame or host read is being handled.
// Reset clears the frame state, the local address and all registers to zero.
// When the receiver stalls, the held result stays on m_axis and the
// sequencer waits.
// ----------------------------------------------------------------------------
module ascii_hex_register_slave_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // rx_char[7:0], reg_index[13:8], reg_data[29:14]
  input  logic [1:0]  s_axis_tuser,   // operation[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // tx_char[7:0], read_data[23:8]
  output logic        m_axis_tuser,   // kind[0]
  output logic        m_axis_tlast
);

  ahx_pkg::emit_t emit;
  logic           slot_free;

  assign slot_free = !m_axis_tvalid || m_axis_tready;

  ahx_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (s_axis_tuser),
    .in_char   (s_axis_tdata[7:0]),
    .in_idx    (s_axis_tdata[13:8]),
    .in_data   (s_axis_tdata[29:14]),
    .slot_free (slot_free),
    .emit      (emit)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit.valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (emit.valid) begin
      m_axis_tdata <= {emit.word, emit.ch};
      m_axis_tuser <= emit.kind;
      m_axis_tlast <= emit.last;
    end
  end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stream testbench for the ascii hex register slave: builds framed requests
// with valid crc, host accesses and noise, predicts every response character
// and host read word, and checks them in order, with random idling before the second address.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  ch;
    logic [5:0]  idx;
    logic [15:0] data;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  ch;
    logic        last;
    logic [15:0] word;
  } out_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  ascii_hex_register_slave_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [15:0] node_addr;
  logic        rx_open, half_pending, rx_overflow;
  logic [7:0]  rx_hi;
  logic [7:0]  rx_buf [ahx_pkg::MaxFrameBytes];
  int          rx_len;
  logic [15:0] reg_file [ahx_pkg::RegCount];

  in_item_t    pending_items [$];
  out_item_t   expected_results [$];
  int          errors = 0;
  int          results_seen = 0;
  int          frames_answered = 0;
  bit          calm = 1'b0;
  int          src_gap = 0, snk_gap = 0;

  function automatic logic [15:0] crc_of(logic [7:0] b [$]);
    logic [15:0] c;
    c = ahx_pkg::CrcInit;
    foreach (b[i]) begin
      c ^= {8'h00, b[i]};
      for (int j = 0; j < 8; j++) c = c[0] ? ((c >> 1) ^ ahx_pkg::CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] nibble_of(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
    if (c >= 8'h41 && c <= 8'h46) return c - 8'h37;
    return c;
  endfunction

  function automatic logic [7:0] hex_of(logic [3:0] v);
    return (v <= 4'd9) ? {4'd0, v} + 8'h30 : {4'd0, v} + 8'h37;
  endfunction

  function automatic logic [7:0] frame_byte(int i);
    return (i < rx_len) ? rx_buf[i] : 8'h00;
  endfunction

  function automatic logic [15:0] reg_value(int a);
    return (a < ahx_pkg::RegCount) ? reg_file[a] : 16'hFFFF;
  endfunction

  function automatic void push_char(logic [7:0] c, logic lst);
    expected_results.push_back('{ahx_pkg::KindChar, c, lst, 16'h0000});
  endfunction

  // evaluate a closed frame and queue its response characters
  function automatic void close_frame_predict();
    logic [7:0]  rsp [$];
    logic [7:0]  body [$];
    logic [15:0] c, d;
    int          a, num;
    logic        status;
    if (rx_overflow || rx_len < ahx_pkg::MinFrame) return;
    if ({frame_byte(5), frame_byte(6)} != node_addr) return;
    for (int i = 0; i < rx_len - 2; i++) body.push_back(rx_buf[i]);
    c = crc_of(body);
    if (frame_byte(rx_len - 2) != c[15:8] || frame_byte(rx_len - 1) != c[7:0]) return;
    if (frame_byte(4) != ahx_pkg::FrameRequest) return;
    rsp = '{frame_byte(0), frame_byte(1), node_addr[15:8], node_addr[7:0],
            ahx_pkg::FrameResponse, frame_byte(5), frame_byte(6), frame_byte(7)};
    a = {frame_byte(8), frame_byte(9)};
    case (frame_byte(7))
      ahx_pkg::FnRead: begin
        d = reg_value(a);
        rsp.push_back(frame_byte(8)); rsp.push_back(frame_byte(9));
        rsp.push_back(d[15:8]); rsp.push_back(d[7:0]);
      end
      ahx_pkg::FnWrite: begin
        if (a < ahx_pkg::RegCount) reg_file[a] = {frame_byte(10), frame_byte(11)};
        rsp.push_back({7'd0, a < ahx_pkg::RegCount});
      end
      ahx_pkg::FnReadMulti: begin
        num = frame_byte(10);
        if (num > ahx_pkg::MaxReadRegs) return;
        rsp.push_back(frame_byte(8)); rsp.push_back(frame_byte(9));
        rsp.push_back(num[7:0]);
        for (int i = 0; i < num; i++) begin
          d = reg_value(a + i);
          rsp.push_back(d[15:8]); rsp.push_back(d[7:0]);
        end
      end
      ahx_pkg::FnWriteMulti: begin
        num = frame_byte(10);
        status = 1'b1;
        for (int i = 0; i < num; i++) begin
          if (a + i < ahx_pkg::RegCount) begin
            reg_file[a + i] = {frame_byte(11 + 2 * i), frame_byte(12 + 2 * i)};
            status = 1'b1;
          end else status = 1'b0;
        end
        rsp.push_back({7'd0, status});
      end
      default: return;
    endcase
    c = crc_of(rsp);
    rsp.push_back(c[15:8]); rsp.push_back(c[7:0]);
    frames_answered++;
    push_char(ahx_pkg::ChStart, 1'b0);
    foreach (rsp[i]) begin
      push_char(hex_of(rsp[i][7:4]), 1'b0);
      push_char(hex_of(rsp[i][3:0]), 1'b0);
    end
    push_char(ahx_pkg::ChEnd, 1'b1);
  endfunction

  // step the predictor with one accepted transaction
  function automatic void predict_item(in_item_t it);
    case (it.op)
      ahx_pkg::OpHostWr: reg_file[it.idx] = it.data;
      ahx_pkg::OpHostRd:
        expected_results.push_back('{ahx_pkg::KindRead, 8'h00, 1'b1, reg_value(it.idx)});
      ahx_pkg::OpChar: begin
        if (it.ch == ahx_pkg::ChStart) begin
          rx_open = 1'b1; half_pending = 1'b0; rx_hi = 8'h00;
          rx_len = 0; rx_overflow = 1'b0;
        end else if (rx_open && it.ch == ahx_pkg::ChEnd) begin
          close_frame_predict();
          rx_open = 1'b0; half_pending = 1'b0;
        end else if (rx_open && !half_pending) begin
          rx_hi = nibble_of(it.ch); half_pending = 1'b1;
        end else if (rx_open) begin
          half_pending = 1'b0;
          if (rx_len < ahx_pkg::MaxFrameBytes) rx_buf[rx_len++] = rx_hi * 8'd16 + nibble_of(it.ch);
          else rx_overflow = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    in_item_t it;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !s_axis_tready) begin
      // hold the offered transaction
    end else begin
      if (s_axis_tvalid) predict_item({s_axis_tuser, s_axis_tdata[7:0],
                                       s_axis_tdata[13:8], s_axis_tdata[29:14]});
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= it.op;
        s_axis_tdata <= {2'b00, it.data, it.idx, it.ch};
        if (!calm && $urandom_range(0, 7) == 0) src_gap <= $urandom_range(1, 13);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor and sink idling
  always @(posedge clk) begin
    out_item_t got, exp_r;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tuser, m_axis_tdata[7:0], m_axis_tlast, m_axis_tdata[23:8]};
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result kind=%0d char=%h word=%h", got.kind, got.ch, got.word);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got.kind !== exp_r.kind) begin
            $error("kind: expected %0d actual %0d", exp_r.kind, got.kind); errors++;
          end
          if (got.ch !== exp_r.ch) begin
            $error("tx_char: expected %h actual %h", exp_r.ch, got.ch); errors++;
          end
          if (got.last !== exp_r.last) begin
            $error("last: expected %0d actual %0d", exp_r.last, got.last); errors++;
          end
          if (got.word !== exp_r.word) begin
            $error("read_data: expected %h actual %h", exp_r.word, got.word); errors++;
          end
        end
      end
      if (snk_gap > 0) begin
        snk_gap <= snk_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        snk_gap <= $urandom_range(0, 12);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // stimulus builders
  task automatic add_item(logic [1:0] op, logic [7:0] ch, logic [5:0] idx, logic [15:0] data);
    pending_items.push_back('{op, ch, idx, data});
  endtask

  task automatic add_char(logic [7:0] ch);
    add_item(ahx_pkg::OpChar, ch, 6'($urandom), 16'($urandom));
  endtask

  // send a byte list as a frame, optionally appending a correct crc
  task automatic add_frame(logic [7:0] b [$], bit with_crc, bit lower_hex);
    logic [15:0] c;
    logic [7:0]  h;
    if (with_crc) begin
      c = crc_of(b);
      b.push_back(c[15:8]); b.push_back(c[7:0]);
    end
    add_char(ahx_pkg::ChStart);
    foreach (b[i]) begin
      for (int k = 1; k >= 0; k--) begin
        h = hex_of(b[i][4*k +: 4]);
        if (lower_hex && h >= 8'h41) h = h + 8'h20;
        add_char(h);
      end
    end
    add_char(ahx_pkg::ChEnd);
  endtask

  function automatic void req_head(ref logic [7:0] b [$], input logic [15:0] dst,
                                   input logic [7:0] fn, input logic [15:0] a);
    b = '{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), ahx_pkg::FrameRequest,
          dst[15:8], dst[7:0], fn, a[15:8], a[7:0]};
  endfunction

  task automatic set_address(logic [15:0] a);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= a;
    node_addr = a;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (2000) @(posedge clk);
  endtask

  // main sequence
  initial begin
    logic [7:0]  b [$];
    logic [15:0] addr2;
    rx_open = 0; half_pending = 0; rx_overflow = 0; rx_hi = 0; rx_len = 0;
    node_addr = 16'h0000;
    foreach (reg_file[i]) reg_file[i] = 16'h0000;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: host accesses at the extremes
    add_item(ahx_pkg::OpHostWr, 8'h00, 6'd0, 16'hFFFF);
    add_item(ahx_pkg::OpHostWr, 8'hFF, 6'd63, 16'h8001);
    add_item(ahx_pkg::OpHostRd, 8'h00, 6'd63, 16'h0000);
    add_item(ahx_pkg::OpHostRd, 8'h00, 6'd1, 16'h0000);
    add_item(2'd3, 8'hFF, 6'd63, 16'hFFFF);
    // characters outside a frame and a stray end
    add_char(8'h41); add_char(ahx_pkg::ChEnd);
    // start inside a frame, odd count and short frame
    add_char(ahx_pkg::ChStart); add_char(8'h31); add_char(ahx_pkg::ChStart);
    add_char(8'h7F); add_char(ahx_pkg::ChEnd);
    // single read at the default node address
    req_head(b, 16'h0000, ahx_pkg::FnRead, 16'd0);  add_frame(b, 1, 0);
    // write multiple running off the end of the register file
    req_head(b, 16'h0000, ahx_pkg::FnWriteMulti, 16'd63);
    b.push_back(8'd2);
    for (int i = 0; i < 4; i++) b.push_back(8'($urandom));
    add_frame(b, 1, 0);
    drain();

    // second node address, no idling from here on
    addr2 = 16'($urandom) | 16'h0100;
    set_address(addr2);
    calm = 1'b1;
    for (int n = 0; n < 4; n++) begin
      if ($urandom_range(0, 1) == 0)
        add_item(ahx_pkg::OpHostWr, 8'($urandom), 6'($urandom), 16'($urandom));
      else
        add_item(ahx_pkg::OpHostRd, 8'($urandom), 6'($urandom), 16'($urandom));
    end
    // read multiple across the top of the register file
    req_head(b, addr2, ahx_pkg::FnReadMulti, 16'd62);
    b.push_back(8'd3);                           add_frame(b, 1, 0);
    drain();

    $display("covered %0d response frames and %0d result transactions over %0d addresses",
             frames_answered, results_seen, 2);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
